// ----- hdl/spq_pkg.sv -----
// Shared types and codes for the sorted priority queue.
// No dependencies; imported by the cell, the top level and the checker.
package spq_pkg;

    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_POP  = 1'b1;

    typedef enum logic [1:0] {
        ERR_OK    = 2'd0,
        ERR_FULL  = 2'd1,
        ERR_EMPTY = 2'd2
    } t_err;

    typedef struct packed {
        logic push;
        logic pop;
    } t_cell_ctrl;

endpackage

// ----- hdl/spq_cell.sv -----
// One slot of the sorted chain: holds a priority and payload word.
// Depends on spq_pkg for the cell control struct.
module spq_cell import spq_pkg::*; #(
    parameter int PRIO_BITS    = 8,
    parameter int PAYLOAD_BITS = 16
) (
    input  logic                    i_clk,
    input  t_cell_ctrl              i_ctrl,
    input  logic                    i_occupied,
    input  logic [PRIO_BITS-1:0]    i_new_priority,
    input  logic [PAYLOAD_BITS-1:0] i_new_payload,
    input  logic                    i_left_stay,
    input  logic [PRIO_BITS-1:0]    i_left_priority,
    input  logic [PAYLOAD_BITS-1:0] i_left_payload,
    input  logic [PRIO_BITS-1:0]    i_right_priority,
    input  logic [PAYLOAD_BITS-1:0] i_right_payload,
    output logic                    o_stay,
    output logic [PRIO_BITS-1:0]    o_priority,
    output logic [PAYLOAD_BITS-1:0] o_payload
);

    logic [PRIO_BITS-1:0]    r_priority;
    logic [PAYLOAD_BITS-1:0] r_payload;

    // held entry keeps its place when it ranks at or above the new word
    assign o_stay     = i_occupied && (r_priority >= i_new_priority);
    assign o_priority = r_priority;
    assign o_payload  = r_payload;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.push) begin
            if (!o_stay) begin
                if (i_left_stay) begin
                    r_priority <= i_new_priority;
                    r_payload  <= i_new_payload;
                end else begin
                    r_priority <= i_left_priority;
                    r_payload  <= i_left_payload;
                end
            end
        end else if (i_ctrl.pop) begin
            r_priority <= i_right_priority;
            r_payload  <= i_right_payload;
        end
    end

endmodule

// ----- hdl/sorted_priority_queue.sv -----
// Sorted priority queue: a chain of spq_cell slots kept in falling priority order.
// Depends on spq_pkg and spq_cell.
//
// Each word is a push or a pop. Unless stalled, one word is accepted every clock cycle
// and its result word appears in the output register on the following cycle; the figure
// is set by the chain of cells, where every slot compares against the new priority and
// shifts in parallel within the same cycle. While a result word is stalled the input is
// stalled too; a new word enters in the same cycle as the previous result is taken.
// Capacity is clamped to 1..DEPTH when written and resets to min(16, DEPTH).
module sorted_priority_queue import spq_pkg::*; #(
    parameter int DEPTH        = 16,
    parameter int PRIO_BITS    = 8,
    parameter int PAYLOAD_BITS = 16,
    localparam int CNT_W       = $clog2(DEPTH + 1)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [4:0]              i_cfg_data,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic                    i_kind,
    input  logic [PRIO_BITS-1:0]    i_new_priority,
    input  logic [PAYLOAD_BITS-1:0] i_new_payload,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic                    o_out_valid,
    output logic [PRIO_BITS-1:0]    o_out_priority,
    output logic [PAYLOAD_BITS-1:0] o_out_payload,
    output t_err                    o_error_code,
    output logic [CNT_W-1:0]        o_fill_level,
    output logic                    o_is_empty,
    output logic                    o_is_full
);

    localparam int CMP_W     = (CNT_W > 5) ? CNT_W : 5;
    localparam int CAP_RESET = (DEPTH < 16) ? DEPTH : 16;

    logic [CNT_W-1:0] r_cap;
    logic [CNT_W-1:0] r_count, n_count;
    logic             accept, full, empty;
    t_cell_ctrl       ctrl;

    logic [PRIO_BITS-1:0]    cell_prio [DEPTH];
    logic [PAYLOAD_BITS-1:0] cell_pay  [DEPTH];
    logic                    cell_stay [DEPTH];

    logic                    r_valid;
    logic                    r_out_valid, n_out_valid;
    logic [PRIO_BITS-1:0]    r_out_priority, n_out_priority;
    logic [PAYLOAD_BITS-1:0] r_out_payload, n_out_payload;
    t_err                    r_error_code, n_error_code;
    logic                    r_is_full, n_is_full;

    assign o_stall = r_valid && i_stall;
    assign accept  = i_valid && !o_stall;
    assign full    = r_count >= r_cap;
    assign empty   = r_count == '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CNT_W'(CAP_RESET);
        end else if (i_cfg_we) begin
            if (i_cfg_data == 5'd0) begin
                r_cap <= CNT_W'(1);
            end else if (CMP_W'(i_cfg_data) > CMP_W'(DEPTH)) begin
                r_cap <= CNT_W'(DEPTH);
            end else begin
                r_cap <= CNT_W'(i_cfg_data);
            end
        end
    end

    always_comb begin
        ctrl.push      = accept && (i_kind == KIND_PUSH) && !full;
        ctrl.pop       = accept && (i_kind == KIND_POP) && !empty;
        n_count        = r_count;
        n_out_valid    = 1'b0;
        n_out_priority = '0;
        n_out_payload  = '0;
        n_error_code   = ERR_OK;
        if (ctrl.push) begin
            n_count = r_count + CNT_W'(1);
        end else if (ctrl.pop) begin
            n_count        = r_count - CNT_W'(1);
            n_out_valid    = 1'b1;
            n_out_priority = cell_prio[0];
            n_out_payload  = cell_pay[0];
        end else if (i_kind == KIND_PUSH) begin
            n_error_code = ERR_FULL;
        end else begin
            n_error_code = ERR_EMPTY;
        end
        n_is_full = n_count >= r_cap;
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic                    left_stay;
        logic [PRIO_BITS-1:0]    left_prio, right_prio;
        logic [PAYLOAD_BITS-1:0] left_pay, right_pay;

        if (g == 0) begin : g_head
            assign left_stay = 1'b1;
            assign left_prio = '0;
            assign left_pay  = '0;
        end else begin : g_mid
            assign left_stay = cell_stay[g-1];
            assign left_prio = cell_prio[g-1];
            assign left_pay  = cell_pay[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign right_prio = '0;
            assign right_pay  = '0;
        end else begin : g_body
            assign right_prio = cell_prio[g+1];
            assign right_pay  = cell_pay[g+1];
        end

        spq_cell #(
            .PRIO_BITS    (PRIO_BITS),
            .PAYLOAD_BITS (PAYLOAD_BITS)
        ) u_cell (
            .i_clk            (i_clk),
            .i_ctrl           (ctrl),
            .i_occupied       (CNT_W'(g) < r_count),
            .i_new_priority   (i_new_priority),
            .i_new_payload    (i_new_payload),
            .i_left_stay      (left_stay),
            .i_left_priority  (left_prio),
            .i_left_payload   (left_pay),
            .i_right_priority (right_prio),
            .i_right_payload  (right_pay),
            .o_stay           (cell_stay[g]),
            .o_priority       (cell_prio[g]),
            .o_payload        (cell_pay[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (accept) begin
                r_valid <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_valid    <= n_out_valid;
            r_out_priority <= n_out_priority;
            r_out_payload  <= n_out_payload;
            r_error_code   <= n_error_code;
            r_is_full      <= n_is_full;
        end
    end

    logic [CNT_W-1:0] r_fill;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_fill <= n_count;
        end
    end

    assign o_valid        = r_valid;
    assign o_out_valid    = r_out_valid;
    assign o_out_priority = r_out_priority;
    assign o_out_payload  = r_out_payload;
    assign o_error_code   = r_error_code;
    assign o_fill_level   = r_fill;
    assign o_is_empty     = r_fill == '0;
    assign o_is_full      = r_is_full;

endmodule

// ----- hdl/spq_checker.sv -----
// Port-level checks for the sorted priority queue, bound to the top level.
// Depends on spq_pkg and sorted_priority_queue.
module spq_checker import spq_pkg::*; #(
    parameter int PRIO_BITS    = 8,
    parameter int PAYLOAD_BITS = 16,
    parameter int CNT_W        = 5
) (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    o_valid,
    input logic                    i_stall,
    input logic                    o_out_valid,
    input logic [PRIO_BITS-1:0]    o_out_priority,
    input logic [PAYLOAD_BITS-1:0] o_out_payload,
    input t_err                    o_error_code,
    input logic [CNT_W-1:0]        o_fill_level,
    input logic                    o_is_empty
);

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_is_empty == (o_fill_level == '0)))
        else $error("empty flag disagrees with fill level");

    a_pop_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out_valid) |-> (o_error_code == ERR_OK))
        else $error("returned entry carries an error");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_error_code != ERR_OK) |->
            (!o_out_valid && o_out_priority == '0 && o_out_payload == '0))
        else $error("rejected word returns data");

    a_empty_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_error_code == ERR_EMPTY) |-> o_is_empty)
        else $error("pop rejected while entries held");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_fill_level)))
        else $error("stalled result word changed");

endmodule

bind sorted_priority_queue spq_checker #(
    .PRIO_BITS    (PRIO_BITS),
    .PAYLOAD_BITS (PAYLOAD_BITS),
    .CNT_W        (CNT_W)
) u_spq_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_out_valid    (o_out_valid),
    .o_out_priority (o_out_priority),
    .o_out_payload  (o_out_payload),
    .o_error_code   (o_error_code),
    .o_fill_level   (o_fill_level),
    .o_is_empty     (o_is_empty)
);

// ----- tb/sv/tb_sorted_priority_queue.sv -----
// Self-checking testbench for sorted_priority_queue: push/pop words, capacity changes,
// random idling on both channels, every result word checked against a software queue.
// Depends on spq_pkg and the sorted_priority_queue RTL.
module tb_sorted_priority_queue;
    import spq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 16;

    typedef struct packed {
        logic        out_valid;
        logic [7:0]  prio;
        logic [15:0] payload;
        t_err        err;
        logic [4:0]  fill;
        logic        empty;
        logic        full;
    } t_queue_result;

    class spq_tracker;
        int unsigned   errors;
        logic [7:0]    held_prio[DEPTH];
        logic [15:0]   held_payload[DEPTH];
        int unsigned   held_count;
        int unsigned   limit;
        t_queue_result pending_results[$];

        function new();
            errors     = 0;
            held_count = 0;
            limit      = DEPTH;
        endfunction

        function void set_capacity(logic [4:0] value);
            if (value == 0) begin
                limit = 1;
            end else if (value > DEPTH) begin
                limit = DEPTH;
            end else begin
                limit = value;
            end
        endfunction

        // Apply one accepted word to the held entries and queue its result.
        function void take_word(logic kind, logic [7:0] prio, logic [15:0] payload);
            t_queue_result r;
            int unsigned   pos;
            r = '0;
            if (kind == KIND_PUSH) begin
                if (held_count >= limit) begin
                    r.err = ERR_FULL;
                end else begin
                    pos = held_count;
                    while (pos > 0 && held_prio[pos-1] < prio) begin
                        held_prio[pos]    = held_prio[pos-1];
                        held_payload[pos] = held_payload[pos-1];
                        pos--;
                    end
                    held_prio[pos]    = prio;
                    held_payload[pos] = payload;
                    held_count++;
                end
            end else if (held_count == 0) begin
                r.err = ERR_EMPTY;
            end else begin
                r.out_valid = 1'b1;
                r.prio      = held_prio[0];
                r.payload   = held_payload[0];
                for (int i = 1; i < held_count; i++) begin
                    held_prio[i-1]    = held_prio[i];
                    held_payload[i-1] = held_payload[i];
                end
                held_count--;
            end
            r.fill  = 5'(held_count);
            r.empty = (held_count == 0);
            r.full  = (held_count >= limit);
            pending_results.push_back(r);
        endfunction

        function void match(string what, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %0h actual %0h", $time, what, want, got);
                errors++;
            end
        endfunction

        function void check_word(logic out_valid, logic [7:0] prio, logic [15:0] payload,
                                 logic [1:0] err, logic [4:0] fill, logic empty, logic full);
            t_queue_result want;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result word, expected none actual valid=%0b prio=%0h",
                         $time, out_valid, prio);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            match("out_valid", want.out_valid, out_valid);
            match("out_priority", want.prio, prio);
            match("out_payload", want.payload, payload);
            match("error_code", want.err, err);
            match("fill_level", want.fill, fill);
            match("is_empty", want.empty, empty);
            match("is_full", want.full, full);
        endfunction

        function int unsigned outstanding();
            return pending_results.size();
        endfunction
    endclass

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_cfg_we       = 1'b0;
    logic [4:0]  i_cfg_data     = '0;
    logic        i_valid        = 1'b0;
    logic        i_kind         = KIND_PUSH;
    logic [7:0]  i_new_priority = '0;
    logic [15:0] i_new_payload  = '0;
    logic        i_stall        = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic        o_out_valid;
    logic [7:0]  o_out_priority;
    logic [15:0] o_out_payload;
    t_err        o_error_code;
    logic [4:0]  o_fill_level;
    logic        o_is_empty;
    logic        o_is_full;

    spq_tracker tracker = new();

    int unsigned gap_pct   = 0;
    int unsigned stall_pct = 0;
    int unsigned hold_left = 0;

    sorted_priority_queue i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_kind         (i_kind),
        .i_new_priority (i_new_priority),
        .i_new_payload  (i_new_payload),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_out_valid    (o_out_valid),
        .o_out_priority (o_out_priority),
        .o_out_payload  (o_out_payload),
        .o_error_code   (o_error_code),
        .o_fill_level   (o_fill_level),
        .o_is_empty     (o_is_empty),
        .o_is_full      (o_is_full)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // receiver: random stall bursts
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
        end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
            hold_left = $urandom_range(1, 18);
        end
        i_stall <= (hold_left > 0);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            tracker.check_word(o_out_valid, o_out_priority, o_out_payload, o_error_code,
                               o_fill_level, o_is_empty, o_is_full);
        end
    end

    task automatic send_word(input logic kind, input logic [7:0] prio,
                             input logic [15:0] payload);
        int unsigned gap;
        i_valid        <= 1'b1;
        i_kind         <= kind;
        i_new_priority <= prio;
        i_new_payload  <= payload;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        tracker.take_word(kind, prio, payload);
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
            gap = $urandom_range(1, 18);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic push_word(input logic [7:0] prio, input logic [15:0] payload);
        send_word(KIND_PUSH, prio, payload);
    endtask

    task automatic pop_word();
        send_word(KIND_POP, 8'($urandom), 16'($urandom));
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (tracker.outstanding() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [4:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        tracker.set_capacity(value);
    endtask

    function automatic logic [7:0] pick_priority();
        case ($urandom_range(0, 2))
            0: return 8'($urandom);
            1: return 8'($urandom_range(0, 3));
            default: return 8'($urandom_range(252, 255));
        endcase
    endfunction

    initial begin
        logic [4:0]  caps[10];
        int unsigned push_pct;

        caps = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd8, 5'd2, 5'd17, 5'd0, 5'd16, 5'd5};
        caps[7] = 5'($urandom);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty pop, extremes, equal priorities
        pop_word();
        push_word(8'h00, 16'h0000);
        push_word(8'hff, 16'hffff);
        push_word(8'hff, 16'h1234);
        push_word(8'h80, 16'haaaa);
        push_word(8'h7f, 16'h5555);
        drain();

        // capacity lowered below the fill count
        write_capacity(5'd2);
        push_word(8'h01, 16'h0001);
        pop_word();
        pop_word();
        pop_word();
        push_word(8'h02, 16'h0002);
        pop_word();
        push_word(8'h80, 16'h8000);
        drain();

        // capacity of zero behaves as one
        write_capacity(5'd0);
        pop_word();
        pop_word();
        pop_word();
        push_word(8'h55, 16'h00ff);
        push_word(8'haa, 16'hff00);
        pop_word();
        drain();

        foreach (caps[p]) begin
            if (p == $size(caps) - 1) begin
                gap_pct   = 0;
                stall_pct = 0;
                hold_left = 0;
            end else begin
                gap_pct   = $urandom_range(0, 2) * 12;
                stall_pct = $urandom_range(0, 2) * 12;
            end
            write_capacity(caps[p]);
            push_pct = 50;
            for (int n = 0; n < 188; n++) begin
                if (n % 40 == 0) begin
                    case ($urandom_range(0, 2))
                        0: push_pct = 25;
                        1: push_pct = 50;
                        default: push_pct = 80;
                    endcase
                end
                if ($urandom_range(0, 99) < push_pct) begin
                    push_word(pick_priority(), 16'($urandom));
                end else begin
                    pop_word();
                end
            end
            drain();
        end

        repeat (10) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.outstanding() == 0) begin
            $display("tb_sorted_priority_queue OK");
        end else begin
            $display("tb_sorted_priority_queue NOT OK");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("tb_sorted_priority_queue NOT OK");
        $finish;
    end

endmodule
